### design/firrb_pkg.sv
`default_nettype none
// ----------------------------------------------------------------------------
// firrb_pkg: shared types for the ring-buffer FIR filter
// Sample, coefficient and accumulator types, the controller/datapath command
// and status bundles, and the register map size.
// ----------------------------------------------------------------------------
package firrb_pkg;

	localparam int NUM_COEF = 8;
	localparam int LINE_DEPTH = 8;
	localparam int PTR_W = 3;
	localparam int ACC_W = 40;
	localparam int PROD_W = 32;
	localparam int FRAC_BITS = 15;
	localparam int ADDR_W = 5;
	localparam int DATA_W = 32;

	typedef logic signed [15:0] sample_t;
	typedef sample_t [NUM_COEF-1:0] coef_vec_t;
	typedef logic [PTR_W-1:0] ptr_t;
	typedef logic signed [ACC_W-1:0] acc_t;
	typedef logic signed [PROD_W-1:0] prod_t;

	// controller -> datapath
	typedef struct packed {
		logic start;     // write the new sample, clear accumulator, set pointers
		logic mac;       // multiply one tap, accumulate previous product
		logic accum;     // accumulate the last product only
		logic load_out;  // scale, saturate and load the output register
	} dp_cmd_t;

	// datapath -> controller
	typedef struct packed {
		logic tap_last;  // current tap is the last one
	} dp_stat_t;

endpackage : firrb_pkg
`default_nettype wire

### design/firrb_regs.sv
`default_nettype none
// ----------------------------------------------------------------------------
// firrb_regs: coefficient register file
// APB-style write/read port for the eight Q1.15 coefficients.
// ----------------------------------------------------------------------------
module firrb_regs (
	input  wire logic                         clk,
	input  wire logic                         arst_n,
	input  wire logic                         psel,
	input  wire logic                         penable,
	input  wire logic                         pwrite,
	input  wire logic [firrb_pkg::ADDR_W-1:0] paddr,
	input  wire logic [firrb_pkg::DATA_W-1:0] pwdata,
	output logic      [firrb_pkg::DATA_W-1:0] prdata,
	output logic                              pready,
	output firrb_pkg::coef_vec_t              coef
);
	import firrb_pkg::*;

	coef_vec_t coef_q;
	ptr_t      reg_idx;
	logic      wr_en;
	sample_t   rd_val;

	assign reg_idx = paddr[ADDR_W-1:2];
	assign pready  = 1'b1;
	assign wr_en   = psel & penable & pwrite & pready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			coef_q <= '0;
		end else if (wr_en) begin
			coef_q[reg_idx] <= sample_t'(pwdata[15:0]);
		end
	end

	assign rd_val = coef_q[reg_idx];
	assign prdata = {{(DATA_W-16){rd_val[15]}}, rd_val};
	assign coef   = coef_q;

endmodule : firrb_regs
`default_nettype wire

### design/firrb_ctrl.sv
`default_nettype none
// ----------------------------------------------------------------------------
// firrb_ctrl: sequencer for the FIR filter
// Steps the datapath through one multiply-accumulate per tap and owns the
// input and output handshakes.
// ----------------------------------------------------------------------------
module firrb_ctrl (
	input  wire logic                clk,
	input  wire logic                arst_n,
	input  wire logic                in_valid,
	output logic                     in_stall,
	output logic                     out_valid,
	input  wire logic                out_stall,
	output firrb_pkg::dp_cmd_t       cmd,
	input  wire firrb_pkg::dp_stat_t stat
);
	import firrb_pkg::*;

	localparam logic [1:0] ST_IDLE = 2'd0;
	localparam logic [1:0] ST_MAC  = 2'd1;
	localparam logic [1:0] ST_LAST = 2'd2;
	localparam logic [1:0] ST_DONE = 2'd3;

	logic [1:0] state_q;
	logic [1:0] state_d;
	logic       out_valid_q;
	logic       out_free;

	assign in_stall  = (state_q != ST_IDLE);
	assign out_valid = out_valid_q;
	assign out_free  = !out_valid_q || !out_stall;

	always_comb begin
		state_d = state_q;
		cmd     = '0;
		unique case (state_q)
			ST_IDLE: begin
				if (in_valid) begin
					cmd.start = 1'b1;
					state_d   = ST_MAC;
				end
			end
			ST_MAC: begin
				cmd.mac = 1'b1;
				if (stat.tap_last) begin
					state_d = ST_LAST;
				end
			end
			ST_LAST: begin
				cmd.accum = 1'b1;
				state_d   = ST_DONE;
			end
			ST_DONE: begin
				// hold the result until the output register frees up
				if (out_free) begin
					cmd.load_out = 1'b1;
					state_d      = ST_IDLE;
				end
			end
			default: state_d = ST_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			if (cmd.load_out) begin
				out_valid_q <= 1'b1;
			end else if (!out_stall) begin
				out_valid_q <= 1'b0;
			end
		end
	end

endmodule : firrb_ctrl
`default_nettype wire

### design/firrb_dp.sv
`default_nettype none
// ----------------------------------------------------------------------------
// firrb_dp: FIR datapath
// Circular delay line, one shared 16x16 multiplier, 40-bit accumulator,
// and the scale/saturate stage feeding the output register.
// ----------------------------------------------------------------------------
module firrb_dp #(
	parameter int TAPS = 8
) (
	input  wire logic                 clk,
	input  wire logic                 arst_n,
	input  wire firrb_pkg::dp_cmd_t   cmd,
	output firrb_pkg::dp_stat_t       stat,
	input  wire firrb_pkg::coef_vec_t coef,
	input  wire firrb_pkg::sample_t   sample_in,
	output firrb_pkg::sample_t        filtered_out,
	output logic                      saturated
);
	import firrb_pkg::*;

	localparam ptr_t LAST_IDX = ptr_t'(TAPS - 1);

	sample_t line_q [LINE_DEPTH];
	ptr_t    wr_pos_q;
	ptr_t    rd_pos_q;
	ptr_t    tap_q;
	prod_t   prod_q;
	acc_t    acc_q;
	acc_t    prod_ext;
	sample_t out_q;
	logic    sat_q;

	logic signed [ACC_W-FRAC_BITS-1:0] scaled;
	logic                              over;
	sample_t                           clipped;

	assign stat.tap_last = (tap_q == LAST_IDX);
	assign prod_ext      = {{(ACC_W-PROD_W){prod_q[PROD_W-1]}}, prod_q};

	// delay line and write pointer
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < LINE_DEPTH; i++) begin
				line_q[i] <= '0;
			end
			wr_pos_q <= '0;
		end else if (cmd.start) begin
			line_q[wr_pos_q] <= sample_in;
			wr_pos_q         <= (wr_pos_q == LAST_IDX) ? '0 : wr_pos_q + ptr_t'(1);
		end
	end

	// tap walk and multiply-accumulate
	always_ff @(posedge clk) begin
		if (cmd.start) begin
			rd_pos_q <= wr_pos_q;
			tap_q    <= '0;
			prod_q   <= '0;
			acc_q    <= '0;
		end else if (cmd.mac) begin
			prod_q   <= $signed(coef[tap_q]) * $signed(line_q[rd_pos_q]);
			acc_q    <= acc_q + prod_ext;
			tap_q    <= tap_q + ptr_t'(1);
			// walk back in time, wrapping at the start of the ring
			rd_pos_q <= (rd_pos_q == '0) ? LAST_IDX : rd_pos_q - ptr_t'(1);
		end else if (cmd.accum) begin
			acc_q <= acc_q + prod_ext;
		end
	end

	// floor shift and clip to 16 bits
	assign scaled  = acc_q[ACC_W-1:FRAC_BITS];
	assign over    = (scaled[ACC_W-FRAC_BITS-1:15] != {(ACC_W-FRAC_BITS-15){scaled[15]}});
	assign clipped = !over ? scaled[15:0]
	               : (scaled[ACC_W-FRAC_BITS-1] ? 16'sh8000 : 16'sh7fff);

	always_ff @(posedge clk) begin
		if (cmd.load_out) begin
			out_q <= clipped;
			sat_q <= over;
		end
	end

	assign filtered_out = out_q;
	assign saturated    = sat_q;

endmodule : firrb_dp
`default_nettype wire

### design/fir_filter_ring_buffer.sv
`default_nettype none
// ----------------------------------------------------------------------------
// fir_filter_ring_buffer: direct-form FIR filter over a circular delay line
// Usage:
//   Input beat (in_valid/in_stall, sample_in Q1.15) is written into an
//   eight-entry ring; the filter then walks TAPS taps, one multiply-
//   accumulate per cycle on a single 16x16 multiplier into a 40-bit
//   accumulator, shifts right by 15 (floor) and saturates to 16 bits.
//   Output beat (out_valid/out_stall) carries filtered_out and saturated,
//   which flags a clipped result.
//   The shared multiplier steps once per tap; the final add, the output
//   load and the idle state in which the next beat is taken follow, so a
//   new sample is taken only after the previous one has been filtered.
//   in_stall stays high while a sample is being filtered; a new sample may
//   be taken while the previous result still waits in the output register.
//   If the receiver stalls, the result is held and the next sample's result
//   waits in the sequencer until the output register frees.
//   Reset clears the coefficients, the delay line and the write pointer.
//   Coefficients coef_0..coef_7 are at byte addresses 0x00..0x1C on the
//   APB port; write them only while the filter is idle.
// ----------------------------------------------------------------------------
module fir_filter_ring_buffer #(
	parameter int TAPS = 8
) (
	input  wire logic                         clk,
	input  wire logic                         arst_n,
	input  wire logic                         psel,
	input  wire logic                         penable,
	input  wire logic                         pwrite,
	input  wire logic [firrb_pkg::ADDR_W-1:0] paddr,
	input  wire logic [firrb_pkg::DATA_W-1:0] pwdata,
	output logic      [firrb_pkg::DATA_W-1:0] prdata,
	output logic                              pready,
	input  wire logic                         in_valid,
	output logic                              in_stall,
	input  wire firrb_pkg::sample_t           sample_in,
	output logic                              out_valid,
	input  wire logic                         out_stall,
	output firrb_pkg::sample_t                filtered_out,
	output logic                              saturated
);
	import firrb_pkg::*;

	coef_vec_t coef;
	dp_cmd_t   cmd;
	dp_stat_t  stat;

	firrb_regs u_regs (
		.clk     (clk),
		.arst_n  (arst_n),
		.psel    (psel),
		.penable (penable),
		.pwrite  (pwrite),
		.paddr   (paddr),
		.pwdata  (pwdata),
		.prdata  (prdata),
		.pready  (pready),
		.coef    (coef)
	);

	firrb_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_stall  (in_stall),
		.out_valid (out_valid),
		.out_stall (out_stall),
		.cmd       (cmd),
		.stat      (stat)
	);

	firrb_dp #(
		.TAPS (TAPS)
	) u_dp (
		.clk          (clk),
		.arst_n       (arst_n),
		.cmd          (cmd),
		.stat         (stat),
		.coef         (coef),
		.sample_in    (sample_in),
		.filtered_out (filtered_out),
		.saturated    (saturated)
	);

endmodule : fir_filter_ring_buffer
`default_nettype wire
